@@ rtl/tkr_pkg.sv @@
`timescale 1ns / 1ps

package tkr_pkg;

   // Field widths
   localparam int OP_W    = 3;
   localparam int ID_W    = 32;
   localparam int RANK_W  = 32;
   localparam int TOTAL_W = 48;
   localparam int K_W     = 4;

   // k_in_use value after reset
   localparam logic [K_W-1:0] DEFAULT_K = 4'd5;

   // Input opcodes
   typedef enum logic [OP_W-1:0] {
      OP_INSERT_VERTEX = 3'd0,
      OP_MERGE_ENTRY   = 3'd1,
      OP_MERGE_TOTAL   = 3'd2,
      OP_REPORT        = 3'd3,
      OP_CLEAR         = 3'd4
   } opcode_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic add_entry;   // insert (id, rank) into the sorted table
      logic add_rank;    // add rank to the running total
      logic add_part;    // add partial total to the running total
      logic clear;       // empty table and zero total
      logic rpt_start;   // latch entry count for a report
      logic rpt_next;    // step to the next reported entry
      logic rpt_end;     // final result taken, empty the table
   } tkr_cmd_type;

endpackage

@@ rtl/tkr_ctrl.sv @@
`timescale 1ns / 1ps

module tkr_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [tkr_pkg::OP_W-1:0]   opcode,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic                       rpt_last,
   output tkr_pkg::tkr_cmd_type       cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EMIT = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decode transactions and sequence the report
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (opcode)
                  tkr_pkg::OP_INSERT_VERTEX: begin
                     cmd.add_entry = 1'b1;
                     cmd.add_rank  = 1'b1;
                  end
                  tkr_pkg::OP_MERGE_ENTRY: begin
                     cmd.add_entry = 1'b1;
                  end
                  tkr_pkg::OP_MERGE_TOTAL: begin
                     cmd.add_part = 1'b1;
                  end
                  tkr_pkg::OP_REPORT: begin
                     cmd.rpt_start = 1'b1;
                     state_in      = S_EMIT;
                  end
                  tkr_pkg::OP_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  default: begin
                     // unknown codes are dropped
                  end
               endcase
            end
         end
         S_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (rpt_last) begin
                  cmd.rpt_end = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  cmd.rpt_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/tkr_datapath.sv @@
`timescale 1ns / 1ps

module tkr_datapath #(
   parameter int MAX_K = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [tkr_pkg::K_W-1:0]       csr_wr_data,
   input  tkr_pkg::tkr_cmd_type          cmd,
   input  logic [tkr_pkg::ID_W-1:0]      node_id,
   input  logic [tkr_pkg::RANK_W-1:0]    rank_value,
   input  logic [tkr_pkg::TOTAL_W-1:0]   partial_total,
   output logic                          rpt_last,
   output logic [tkr_pkg::ID_W-1:0]      out_node_id,
   output logic [tkr_pkg::RANK_W-1:0]    out_rank,
   output logic [tkr_pkg::TOTAL_W-1:0]   running_total,
   output logic                          entry_valid
);

   localparam int CNT_W = $clog2(MAX_K + 1);
   localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int KX_W  = (CNT_W > tkr_pkg::K_W) ? CNT_W : tkr_pkg::K_W;

   // Table kept sorted best first: higher rank, then smaller id
   logic [tkr_pkg::RANK_W-1:0]  ent_rank_ff [MAX_K];
   logic [tkr_pkg::ID_W-1:0]    ent_id_ff   [MAX_K];
   logic [tkr_pkg::RANK_W-1:0]  ent_rank_in [MAX_K];
   logic [tkr_pkg::ID_W-1:0]    ent_id_in   [MAX_K];
   logic [MAX_K-1:0]            stay;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            remain_ff, remain_in;
   logic [tkr_pkg::K_W-1:0]     k_ff;
   logic [tkr_pkg::TOTAL_W-1:0] sum_ff, sum_in;
   logic [tkr_pkg::TOTAL_W-1:0] addend;
   logic [tkr_pkg::TOTAL_W:0]   sum_wide;
   logic [CNT_W-1:0]            keff;
   logic [CNT_W:0]              cnt_inc;
   logic [CNT_W-1:0]            count_add;
   logic [CNT_W-1:0]            rd_pos;
   logic [IDX_W-1:0]            rd_idx;

   // Clamp k to the built depth
   always_comb begin
      if (KX_W'(k_ff) > KX_W'(MAX_K)) begin
         keff = CNT_W'(MAX_K);
      end else begin
         keff = CNT_W'(k_ff);
      end
      cnt_inc = {1'b0, count_ff} + (CNT_W + 1)'(1);
      if (cnt_inc > {1'b0, keff}) begin
         count_add = keff;
      end else begin
         count_add = cnt_inc[CNT_W-1:0];
      end
   end

   // Mark held entries that stay ahead of the new one, then shift the rest down
   always_comb begin
      for (int i = 0; i < MAX_K; i++) begin
         stay[i] = (i < int'(count_ff)) &&
                   !((rank_value > ent_rank_ff[i]) ||
                     ((rank_value == ent_rank_ff[i]) && (node_id < ent_id_ff[i])));
      end
      for (int j = 0; j < MAX_K; j++) begin
         if (stay[j]) begin
            ent_rank_in[j] = ent_rank_ff[j];
            ent_id_in[j]   = ent_id_ff[j];
         end else if (j == 0) begin
            ent_rank_in[j] = rank_value;
            ent_id_in[j]   = node_id;
         end else if (stay[(j > 0) ? j - 1 : 0]) begin
            ent_rank_in[j] = rank_value;
            ent_id_in[j]   = node_id;
         end else begin
            ent_rank_in[j] = ent_rank_ff[(j > 0) ? j - 1 : 0];
            ent_id_in[j]   = ent_id_ff[(j > 0) ? j - 1 : 0];
         end
      end
   end

   // Hold table entries
   always_ff @(posedge clock) begin
      if (cmd.add_entry) begin
         for (int j = 0; j < MAX_K; j++) begin
            ent_rank_ff[j] <= ent_rank_in[j];
            ent_id_ff[j]   <= ent_id_in[j];
         end
      end
   end

   // Saturating total
   always_comb begin
      addend   = cmd.add_rank ? tkr_pkg::TOTAL_W'(rank_value) : partial_total;
      sum_wide = {1'b0, sum_ff} + {1'b0, addend};
      sum_in   = sum_ff;
      if (cmd.clear) begin
         sum_in = '0;
      end else if (cmd.add_rank || cmd.add_part) begin
         sum_in = sum_wide[tkr_pkg::TOTAL_W] ? '1 : sum_wide[tkr_pkg::TOTAL_W-1:0];
      end
   end

   // Entry count and report position
   always_comb begin
      count_in  = count_ff;
      remain_in = remain_ff;
      if (cmd.clear || cmd.rpt_end) begin
         count_in = '0;
      end else if (cmd.add_entry) begin
         count_in = count_add;
      end
      if (cmd.rpt_start) begin
         remain_in = count_ff;
      end else if (cmd.rpt_next) begin
         remain_in = remain_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         remain_ff <= '0;
         sum_ff    <= '0;
         k_ff      <= tkr_pkg::DEFAULT_K;
      end else begin
         count_ff  <= count_in;
         remain_ff <= remain_in;
         sum_ff    <= sum_in;
         if (csr_wr_en) begin
            k_ff <= csr_wr_data;
         end
      end
   end

   // Emit worst first: walk the sorted table from its tail
   always_comb begin
      rd_pos        = remain_ff - CNT_W'(1);
      rd_idx        = rd_pos[IDX_W-1:0];
      entry_valid   = (remain_ff != '0);
      rpt_last      = (remain_ff <= CNT_W'(1));
      running_total = sum_ff;
      if (entry_valid) begin
         out_node_id = ent_id_ff[rd_idx];
         out_rank    = ent_rank_ff[rd_idx];
      end else begin
         out_node_id = '0;
         out_rank    = '0;
      end
   end

endmodule

@@ rtl/top_k_rank_tracker.sv @@
`timescale 1ns / 1ps

// Top-K rank tracker.
// Input stream req_*: one transaction per command; the opcode travels in
// req_tuser, the vertex id, Q16.16 rank and Q32.16 partial total in req_tdata.
// Insert, merge and clear transactions take effect in the cycle they are
// accepted, so they stream at one per cycle while no report is being returned.
// A report transaction returns the held entries on rsp_* from lowest to
// highest rank (larger id first among equal ranks), each carrying the running
// total; rsp_tlast marks the final one and rsp_tuser flags a real entry. An
// empty table yields one result with the flag low.
// The first result is offered the cycle after the report is accepted, then
// one result per cycle the receiver takes; a report of n entries (one result
// when empty) holds the block until its final result is taken, which also
// empties the table; the single read position walks the sorted register
// table. While results are pending req_tready stays low; a stalled receiver
// simply holds the current result.
// The csr_* port writes k_in_use (entries kept, clamped to MAX_K); write it
// only while idle.
// Reset (synchronous, active high) empties the table, zeroes the total and
// sets k_in_use to 5.
module top_k_rank_tracker #(
   parameter int MAX_K = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,   // node_id[31:0], rank_value[63:32], partial_total[111:64]
   input  logic [2:0]   req_tuser,   // opcode[2:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // out_node_id[31:0], out_rank[63:32], running_total[111:64]
   output logic [0:0]   rsp_tuser,   // entry_valid[0]
   output logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [3:0]   csr_wr_data
);

   tkr_pkg::tkr_cmd_type          cmd;
   logic                          rpt_last;
   logic [tkr_pkg::ID_W-1:0]      out_node_id;
   logic [tkr_pkg::RANK_W-1:0]    out_rank;
   logic [tkr_pkg::TOTAL_W-1:0]   running_total;
   logic                          entry_valid;

   tkr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .opcode     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rpt_last   (rpt_last),
      .cmd        (cmd)
   );

   tkr_datapath #(
      .MAX_K (MAX_K)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .cmd           (cmd),
      .node_id       (req_tdata[31:0]),
      .rank_value    (req_tdata[63:32]),
      .partial_total (req_tdata[111:64]),
      .rpt_last      (rpt_last),
      .out_node_id   (out_node_id),
      .out_rank      (out_rank),
      .running_total (running_total),
      .entry_valid   (entry_valid)
   );

   // Pack the result
   assign rsp_tdata = {running_total, out_rank, out_node_id};
   assign rsp_tuser = entry_valid;
   assign rsp_tlast = rpt_last;

   // No new command while a report is being returned
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted during report");

   // Report ends after the final result is taken
   a_report_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("result offered after final result");

   // An empty result is always the final one
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> rsp_tlast)
      else $error("empty result not marked last");

   // Report begins the cycle after its command is accepted
   a_report_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == tkr_pkg::OP_REPORT)) |=> rsp_tvalid)
      else $error("report did not start");

endmodule
